// ===== hw/rtl/teadec_pkg.sv =====
package teadec_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned NUM_KEYS = 4;
  localparam int unsigned KEY_IDX_W = 2;

  localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9E37_79B9;
  localparam logic [WORD_W-1:0] SUM_STEP  = 32'h61C8_8647;

  typedef logic [WORD_W-1:0] word_t;

  // Configuration register indexes
  typedef enum logic [KEY_IDX_W-1:0] {
    REG_KEY_WORD0 = 2'd0,
    REG_KEY_WORD1 = 2'd1,
    REG_KEY_WORD2 = 2'd2,
    REG_KEY_WORD3 = 2'd3
  } reg_idx_t;

  typedef struct packed {
    word_t w0;
    word_t w1;
  } blk_t;

  typedef struct packed {
    word_t k0;
    word_t k1;
    word_t k2;
    word_t k3;
  } key_t;

  // TEA mixing term, with arithmetic right shift by five
  function automatic word_t tea_mix(word_t w, word_t sum, word_t kshl, word_t ksar);
    word_t a;
    word_t b;
    word_t c;
    a = word_t'($signed(w) >>> 5) + ksar;
    b = (w << 4) + kshl;
    c = sum + w;
    return a ^ b ^ c;
  endfunction

endpackage

// ===== hw/rtl/teadec_ifs.sv =====
interface teadec_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] cipher_word0;
  logic [31:0] cipher_word1;

  modport source (output valid, output cipher_word0, output cipher_word1, input ready);
  modport sink   (input valid, input cipher_word0, input cipher_word1, output ready);
endinterface

interface teadec_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] plain_word0;
  logic [31:0] plain_word1;

  modport source (output valid, output plain_word0, output plain_word1, input ready);
  modport sink   (input valid, input plain_word0, input plain_word1, output ready);
endinterface

// ===== hw/rtl/teadec_half_rnd.sv =====
module teadec_half_rnd
  import teadec_pkg::*;
#(
  parameter logic [31:0] SUM_VAL = 32'h0,
  parameter bit          UPD_W1  = 1'b1
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  key_t key,
  input  logic valid_in,
  input  blk_t blk_in,
  output logic valid_out,
  output blk_t blk_out
);

  logic valid_r;
  blk_t blk_r;
  blk_t blk_nxt;

  // updates the second word when UPD_W1 is set, else the first word; the other word passes through
  always_comb begin
    blk_nxt = blk_in;
    if (UPD_W1) begin
      blk_nxt.w1 = blk_in.w1 - tea_mix(blk_in.w0, SUM_VAL, key.k2, key.k3);
    end else begin
      blk_nxt.w0 = blk_in.w0 - tea_mix(blk_in.w1, SUM_VAL, key.k0, key.k1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      blk_r <= blk_nxt;
    end
  end

  assign valid_out = valid_r;
  assign blk_out   = blk_r;

endmodule

// ===== hw/rtl/teadec_out_buf.sv =====
module teadec_out_buf
  import teadec_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  blk_t push_blk,
  output logic full,
  output logic out_valid,
  input  logic out_ready,
  output blk_t out_blk
);

  logic head_v_r;
  logic head_v_nxt;
  logic skid_v_r;
  logic skid_v_nxt;
  blk_t head_r;
  blk_t head_nxt;
  blk_t skid_r;
  blk_t skid_nxt;
  logic pop;

  assign pop = head_v_r && out_ready;

  // skid fills if head is held or skid moves to head; caller must not push while skid is full (block does not refuse)
  always_comb begin
    head_v_nxt = head_v_r;
    head_nxt   = head_r;
    skid_v_nxt = skid_v_r;
    skid_nxt   = skid_r;
    if (!head_v_r || pop) begin
      if (skid_v_r) begin
        head_v_nxt = 1'b1;
        head_nxt   = skid_r;
        skid_v_nxt = push;
        skid_nxt   = push_blk;
      end else begin
        head_v_nxt = push;
        head_nxt   = push_blk;
      end
    end else if (push) begin
      skid_v_nxt = 1'b1;
      skid_nxt   = push_blk;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      head_v_r <= head_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_v_r;
  assign out_valid = head_v_r;
  assign out_blk   = head_r;

endmodule

// ===== hw/rtl/tea_block_decrypt_top.sv =====
// TEA block decryption (32-round default, arithmetic right shift variant).
// in_chan  : valid/ready transaction carrying cipher_word0/cipher_word1.
// out_chan : valid/ready transaction carrying plain_word0/plain_word1.
// cfg_*    : plain write port; cfg_index 0..3 selects key_word0..key_word3,
//            written at any clock edge with cfg_we high. Write keys only
//            while no block is in flight.
// Pipeline : one register stage per half round, each stage one mix
//            (shift, add, xor) and one subtract, followed by the
//            output register.
// Throughput: one block per cycle, sustained, while out_chan is ready.
// Stall    : a two-entry output buffer (head + skid) sits after the last
//            round stage. The pipeline keeps accepting while one result
//            waits; only once the skid entry is full does the whole pipeline
//            hold and in_chan.ready drop. Nothing is dropped or duplicated.
// Reset    : rst_n (synchronous, active low) clears all valid bits and the
//            key registers to zero.
module tea_block_decrypt_top
  import teadec_pkg::*;
#(
  parameter int unsigned ROUNDS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  teadec_in_if.sink            in_chan,
  teadec_out_if.source         out_chan,
  input  logic                 cfg_we,
  input  logic [KEY_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  localparam int unsigned NUM_STAGES = 2 * ROUNDS;

  // starting sum is ROUNDS * delta, mod 2^32
  localparam logic [63:0] SUM_INIT_W = 64'(ROUNDS) * 64'(TEA_DELTA);
  localparam logic [WORD_W-1:0] SUM_INIT = SUM_INIT_W[WORD_W-1:0];

  key_t key_r;
  key_t key_nxt;

  // key registers
  always_comb begin
    key_nxt = key_r;
    if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_KEY_WORD0: key_nxt.k0 = cfg_data;
        REG_KEY_WORD1: key_nxt.k1 = cfg_data;
        REG_KEY_WORD2: key_nxt.k2 = cfg_data;
        REG_KEY_WORD3: key_nxt.k3 = cfg_data;
        default:       key_nxt = key_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else begin
      key_r <= key_nxt;
    end
  end

  // pipeline advances as a whole unless the output skid entry is occupied
  logic buf_full;
  logic pipe_en;
  assign pipe_en       = !buf_full;
  assign in_chan.ready = pipe_en;

  logic stg_valid [NUM_STAGES+1];
  blk_t stg_blk   [NUM_STAGES+1];

  assign stg_valid[0]  = in_chan.valid;
  assign stg_blk[0].w0 = in_chan.cipher_word0;
  assign stg_blk[0].w1 = in_chan.cipher_word1;

  // even stage: second word update; odd stage: first word update.
  // The round sum is a per-stage constant.
  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
    localparam logic [63:0] SUM_OFS_W = 64'(s / 2) * 64'(SUM_STEP);
    localparam logic [WORD_W-1:0] STG_SUM = SUM_INIT + SUM_OFS_W[WORD_W-1:0];

    teadec_half_rnd #(
      .SUM_VAL (STG_SUM),
      .UPD_W1  ((s % 2) == 0)
    ) u_half (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (pipe_en),
      .key       (key_r),
      .valid_in  (stg_valid[s]),
      .blk_in    (stg_blk[s]),
      .valid_out (stg_valid[s+1]),
      .blk_out   (stg_blk[s+1])
    );
  end

  blk_t out_blk;

  teadec_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (pipe_en && stg_valid[NUM_STAGES]),
    .push_blk  (stg_blk[NUM_STAGES]),
    .full      (buf_full),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_blk   (out_blk)
  );

  assign out_chan.plain_word0 = out_blk.w0;
  assign out_chan.plain_word1 = out_blk.w1;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import teadec_pkg::*;

  localparam int unsigned ROUNDS_TB = 32;
  // Input transaction to output valid, through the half-round stages and the output register
  localparam int unsigned PIPE_LATENCY = 2 * ROUNDS_TB + 1;
  // Cycles with no transaction on any port before the run is abandoned.
  // The slowest correct stretch is a full pipeline plus a long stall or gap
  // on each side.
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst_n;

  teadec_in_if  in_if();
  teadec_out_if out_if();

  logic       cfg_we;
  reg_idx_t   cfg_index;
  word_t      cfg_data;

  // Mirror of the key registers, updated as each write lands
  word_t      key_tab [NUM_KEYS];
  // Decrypted blocks still owed by the pipeline, oldest first
  blk_t       plain_q [$];

  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  int          sink_left = 0;
  bit          src_gaps_on = 1'b1;
  bit          sink_stalls_on = 1'b1;

  always #5 clk = ~clk;

  tea_block_decrypt_top #(
    .ROUNDS(ROUNDS_TB)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  // One half-round mixing term; the right shift copies the sign bit
  function automatic word_t round_term(word_t w, word_t s, word_t k_shl, word_t k_shr);
    word_t shr5;
    shr5 = {{5{w[WORD_W-1]}}, w[WORD_W-1:5]};
    return (shr5 + k_shr) ^ ((w << 4) + k_shl) ^ (s + w);
  endfunction

  // Full decryption of one block under the keys currently held
  function automatic blk_t decrypt_block(blk_t c);
    word_t v0;
    word_t v1;
    word_t s;
    blk_t  p;
    v0 = c.w0;
    v1 = c.w1;
    s  = word_t'(TEA_DELTA * ROUNDS_TB);
    for (int r = 0; r < ROUNDS_TB; r++) begin
      v1 = v1 - round_term(v0, s, key_tab[REG_KEY_WORD2], key_tab[REG_KEY_WORD3]);
      v0 = v0 - round_term(v1, s, key_tab[REG_KEY_WORD0], key_tab[REG_KEY_WORD1]);
      s  = s + SUM_STEP;
    end
    p.w0 = v0;
    p.w1 = v1;
    return p;
  endfunction

  // ---------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------

  // Mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  // Words biased towards zero, all-ones, sign-bit and single-bit corners
  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return word_t'(1) << $urandom_range(0, WORD_W - 1);
      default: return $urandom();
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Key port
  // ---------------------------------------------------------------------

  // Leaves cfg_we high; load_keys drops it once after the last write
  task automatic put_key(reg_idx_t idx, word_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    key_tab[idx] = val;
  endtask

  task automatic load_keys(word_t k0, word_t k1, word_t k2, word_t k3);
    put_key(REG_KEY_WORD0, k0);
    put_key(REG_KEY_WORD1, k1);
    put_key(REG_KEY_WORD2, k2);
    put_key(REG_KEY_WORD3, k3);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------

  // Offers one block and returns on the edge that accepts it. valid stays
  // high afterwards so that back-to-back transactions need no extra step.
  task automatic send_block(word_t c0, word_t c1);
    int   gap;
    blk_t c;
    gap = src_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.cipher_word0 <= c0;
    in_if.cipher_word1 <= c1;
    do @(posedge clk); while (!in_if.ready);
    c.w0 = c0;
    c.w1 = c1;
    plain_q.push_back(decrypt_block(c));
  endtask

  // Stops offering and waits until every owed block has come out; the keys
  // may then be rewritten safely since nothing is left in the pipeline.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (plain_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Output side: ready toggles in runs and gaps
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    if (sink_left > 0) begin
      sink_left--;
    end else if (!sink_stalls_on) begin
      out_if.ready <= 1'b1;
    end else if (out_if.ready) begin
      sink_left = pick_gap();
      if (sink_left > 0) begin
        out_if.ready <= 1'b0;
        sink_left--;
      end else begin
        sink_left = $urandom_range(0, 12);
      end
    end else begin
      out_if.ready <= 1'b1;
      sink_left = $urandom_range(0, 12);
    end
  end

  // Result check: every output transaction against the oldest owed block
  always @(posedge clk) begin
    blk_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (plain_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result w0=%h w1=%h", out_if.plain_word0, out_if.plain_word1);
      end else begin
        want = plain_q.pop_front();
        if (out_if.plain_word0 !== want.w0 || out_if.plain_word1 !== want.w1) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("mismatch: w0 exp %h got %h, w1 exp %h got %h",
                     want.w0, out_if.plain_word0, want.w1, out_if.plain_word1);
        end
      end
    end
  end

  // Watchdog: a run of cycles with nothing moving on any port
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Keys straight out of reset (all zero) with corner-case blocks; the
  // sign-bit patterns exercise the sign-extending shift
  task automatic test_zero_key_extremes();
    send_block(32'h0000_0000, 32'h0000_0000);
    send_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_block(32'h8000_0000, 32'h0000_0000);
    send_block(32'h0000_0000, 32'h8000_0000);
    send_block(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_block(32'hAAAA_AAAA, 32'h5555_5555);
    drain();
  endtask

  // All-ones key, then each key word alone at all ones, so each one's
  // place in the round is seen on its own
  task automatic test_key_extremes();
    word_t k [NUM_KEYS];
    for (int s = 0; s <= NUM_KEYS; s++) begin
      for (int i = 0; i < NUM_KEYS; i++)
        k[i] = (s == 0 || s == i + 1) ? '1 : '0;
      load_keys(k[0], k[1], k[2], k[3]);
      send_block(32'h8000_0000, 32'h8000_0000);
      send_block(32'hFFFF_FFFF, 32'h0000_0000);
      send_block(32'h5555_5555, 32'hAAAA_AAAA);
      drain();
    end
  endtask

  // Full rate: no gaps on either side, one transaction per cycle while in_chan is ready
  task automatic test_full_throughput(int n_items);
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    load_keys($urandom(), $urandom(), $urandom(), $urandom());
    repeat (n_items) send_block(rand_word(), rand_word());
    drain();
  endtask

  // Sender never pauses while the sink stalls, filling the skid buffer
  // and forcing the pipeline to hold
  task automatic test_output_backpressure(int n_items);
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b1;
    load_keys(rand_word(), rand_word(), rand_word(), rand_word());
    repeat (n_items) send_block(rand_word(), rand_word());
    drain();
  endtask

  // Several key settings, gaps and stalls on both sides
  task automatic test_random_traffic(int n_phases, int per_phase);
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b1;
    for (int p = 0; p < n_phases; p++) begin
      load_keys(rand_word(), rand_word(), rand_word(), rand_word());
      repeat (per_phase) send_block(rand_word(), rand_word());
      drain();
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = REG_KEY_WORD0;
    cfg_data           = '0;
    in_if.valid        = 1'b0;
    in_if.cipher_word0 = '0;
    in_if.cipher_word1 = '0;
    out_if.ready       = 1'b0;
    for (int i = 0; i < NUM_KEYS; i++) key_tab[i] = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_zero_key_extremes();
    test_key_extremes();
    test_full_throughput(300);
    test_output_backpressure(300);
    test_random_traffic(5, 250);

    // Let anything stray work its way out before the verdict
    drain();
    repeat (PIPE_LATENCY + 10) @(posedge clk);
    if (fail_count == 0 && plain_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
